// ===== design/sfs_pkg.sv =====
// Shared constants, codes and types of the sprite frame sequencer.
`default_nettype none

package sfs_pkg;

    localparam int FRAME_MAX_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_CROSS     = 64;
    localparam int LEFT_W        = 7;
    localparam int QUEUE_DEPTH   = 2;

    localparam int FUNC_W      = 3;
    localparam int PSTEP_W     = 22;
    localparam int PSTEP_LSB   = 0;
    localparam int TGT_W       = 16;
    localparam int TGT_LSB     = 22;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = 5;
    localparam int FRAME_OUT_W = 8;
    localparam int COORD_W     = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int COUNT_W    = 9;
    localparam int MODE_W     = 2;
    localparam int COLS_W     = 9;
    localparam int STRIDE_W   = 13;
    localparam int PAD_W      = 12;

    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT   = 3'd0,
        CFG_PLAY_MODE     = 3'd1,
        CFG_SHEET_COLUMNS = 3'd2,
        CFG_STRIDE_X      = 3'd3,
        CFG_STRIDE_Y      = 3'd4,
        CFG_PAD_X         = 3'd5,
        CFG_PAD_Y         = 3'd6
    } t_cfg_idx;

    typedef enum logic [FUNC_W-1:0] {
        OP_TICK    = 3'd0,
        OP_RESTART = 3'd1,
        OP_RESUME  = 3'd2,
        OP_STOP    = 3'd3,
        OP_REWIND  = 3'd4,
        OP_SEEK    = 3'd5
    } t_op;

    typedef struct packed {
        logic [COUNT_W-1:0]  frame_count;
        logic [MODE_W-1:0]   play_mode;
        logic [COLS_W-1:0]   sheet_columns;
        logic [STRIDE_W-1:0] stride_x;
        logic [STRIDE_W-1:0] stride_y;
        logic [PAD_W-1:0]    pad_x;
        logic [PAD_W-1:0]    pad_y;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/sfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module sfs_div #(
    parameter int N_W = 8,
    parameter int D_W = 9
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot,
    output logic [D_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [N_W-1:0]   r_q, n_q;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den, n_den;

    logic [D_W:0] rem_sh;
    logic [D_W:0] rem_sub;
    logic         ge;

    assign rem_sh  = {r_rem, r_q[N_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N_W);
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
            n_q   = (r_q << 1) | N_W'(ge);
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== design/sfs_queue.sv =====
// Short register queue between the classifying front and the executing back.
`default_nettype none

module sfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_push_ready,
    input  wire logic             i_pop,
    output logic                  o_pop_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic do_push, do_pop;

    assign o_push_ready = r_fill != FILL_W'(DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfs_front.sv =====
// Input stage: takes beats, drops unknown codes, clamps the seek target.
`default_nettype none

module sfs_front #(
    parameter int FI_W  = 8,
    parameter int CNT_W = 9
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [sfs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [sfs_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  wire logic [CNT_W-1:0]                i_cnt,
    input  wire logic                            i_push_ready,
    output logic                                 o_push,
    output sfs_pkg::t_op                         o_op,
    output logic [sfs_pkg::PSTEP_W-1:0]          o_step,
    output logic [FI_W-1:0]                      o_seek
);

    localparam int CMP_W = sfs_pkg::TGT_W + 1;

    logic                         r_valid;
    sfs_pkg::t_op                 r_op;
    logic [sfs_pkg::PSTEP_W-1:0]  r_step;
    logic [FI_W-1:0]              r_seek;

    logic                         accept;
    logic                         known;
    logic [sfs_pkg::TGT_W-1:0]    tgt;
    logic [CMP_W-1:0]             tgt_e;
    logic [CMP_W-1:0]             cnt_e;
    logic [CNT_W-1:0]             cnt_m1;
    logic [FI_W-1:0]              seek;

    assign o_s_tready = !r_valid || i_push_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign tgt        = i_s_tdata[sfs_pkg::TGT_LSB +: sfs_pkg::TGT_W];
    assign tgt_e      = {1'b0, tgt};
    assign cnt_e      = CMP_W'(i_cnt);
    assign cnt_m1     = i_cnt - CNT_W'(1);

    always_comb begin
        unique case (i_s_tuser) inside
            sfs_pkg::OP_TICK, sfs_pkg::OP_RESTART, sfs_pkg::OP_RESUME,
            sfs_pkg::OP_STOP, sfs_pkg::OP_REWIND, sfs_pkg::OP_SEEK: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    always_comb begin
        if (i_cnt == '0 || tgt[sfs_pkg::TGT_W-1]) begin
            seek = '0;
        end else if (tgt_e >= cnt_e) begin
            seek = cnt_m1[FI_W-1:0];
        end else begin
            seek = tgt[FI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= known;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_op   <= sfs_pkg::t_op'(i_s_tuser);
            r_step <= i_s_tdata[sfs_pkg::PSTEP_LSB +: sfs_pkg::PSTEP_W];
            r_seek <= seek;
        end
    end

    assign o_push = r_valid;
    assign o_op   = r_op;
    assign o_step = r_step;
    assign o_seek = r_seek;

endmodule

`default_nettype wire

// ===== design/sfs_back.sv =====
// Execution stage: playback state, frame stepping, sheet position and result register.
`default_nettype none

module sfs_back #(
    parameter int FI_W      = 8,
    parameter int CNT_W     = 9,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_pop_valid,
    output logic                                 o_pop,
    input  wire sfs_pkg::t_op                    i_op,
    input  wire logic [sfs_pkg::PSTEP_W-1:0]     i_step,
    input  wire logic [FI_W-1:0]                 i_seek,
    input  wire logic [CNT_W-1:0]                i_cnt,
    input  wire sfs_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_cols_wr,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [sfs_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [sfs_pkg::OUT_TUSER_W-1:0]      o_m_tuser,
    output logic                                 o_m_tlast
);

    localparam int STEP_W = sfs_pkg::PSTEP_W;
    localparam int TOT_W  = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
    localparam int WH_W   = TOT_W - FRAC_BITS;
    localparam int CW     = (WH_W > sfs_pkg::LEFT_W) ? WH_W : sfs_pkg::LEFT_W;
    localparam int LW     = sfs_pkg::LEFT_W;
    localparam int COL_W  = sfs_pkg::COLS_W;
    localparam int RX_W   = COL_W + sfs_pkg::STRIDE_W;
    localparam int RY_W   = FI_W + sfs_pkg::STRIDE_W;
    localparam int SX_W   = (RX_W + 1 > 17) ? RX_W + 1 : 17;
    localparam int SY_W   = (RY_W + 1 > 17) ? RY_W + 1 : 17;
    localparam int FE_W   = CNT_W + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_STEP = 6'b000010,
        S_FIX  = 6'b000100,
        S_DIV  = 6'b001000,
        S_EMIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [FI_W-1:0]        r_frame, n_frame;
    logic                   r_dir, n_dir;
    logic [FRAC_BITS-1:0]   r_frac, n_frac;
    logic                   r_run, n_run;
    logic [COL_W-1:0]       r_col, n_col;
    logic [FI_W-1:0]        r_row, n_row;
    logic                   r_ok, n_ok;
    logic [LW-1:0]          r_left, n_left;
    logic                   r_ev, n_ev;
    logic                   r_fin, n_fin;
    logic                   r_last, n_last;
    logic [RX_W-1:0]        r_px, n_px;
    logic [RY_W-1:0]        r_py, n_py;
    logic                   r_m_valid, n_m_valid;
    logic [sfs_pkg::OUT_TDATA_W-1:0] r_m_data, n_m_data;
    logic [sfs_pkg::OUT_TUSER_W-1:0] r_m_user, n_m_user;
    logic                   r_m_last, n_m_last;

    logic                   cnt_nz;
    logic                   mode_pp, mode_once;
    logic [FE_W-1:0]        frame_e, cnt_e, cm1_e, inc_e, dec_e;
    logic [FI_W-1:0]        cm1;
    logic [FI_W-1:0]        st_frame;
    logic                   st_dir, st_run, st_fin;
    logic [TOT_W-1:0]       total;
    logic [CW-1:0]          whole_e;
    logic [LW-1:0]          whole_cap;
    logic [FI_W-1:0]        nf;
    logic [FI_W:0]          nf_e;
    logic [COL_W:0]         col_inc;
    logic [COL_W-1:0]       pos_col;
    logic [FI_W-1:0]        pos_row;
    logic                   pos_ok;
    logic                   coords_ok;
    logic [SX_W-1:0]        sum_x;
    logic [SY_W-1:0]        sum_y;
    logic [sfs_pkg::COORD_W-1:0] x_out, y_out;
    logic                   div_start, div_done;
    logic [FI_W-1:0]        div_quot;
    logic [COL_W-1:0]       div_rem;
    logic                   out_free;

    assign cnt_nz    = i_cnt != '0;
    assign mode_pp   = i_cfg.play_mode == sfs_pkg::MODE_PINGPONG;
    assign mode_once = i_cfg.play_mode == sfs_pkg::MODE_ONCE;
    assign frame_e   = FE_W'(r_frame);
    assign cnt_e     = FE_W'(i_cnt);
    assign cm1_e     = cnt_e - FE_W'(1);
    assign cm1       = cm1_e[FI_W-1:0];
    assign inc_e     = frame_e + FE_W'(1);
    assign dec_e     = frame_e - FE_W'(1);
    assign coords_ok = (i_cfg.sheet_columns != '0) && cnt_nz;
    assign out_free  = !r_m_valid || i_m_tready;

    // One crossing in the current play mode.
    always_comb begin
        st_frame = r_frame;
        st_dir   = r_dir;
        st_run   = r_run;
        st_fin   = 1'b0;
        if (mode_pp) begin
            if (!r_dir) begin
                if (inc_e >= cm1_e) begin
                    st_frame = cm1;
                    st_dir   = 1'b1;
                end else begin
                    st_frame = inc_e[FI_W-1:0];
                end
            end else if (r_frame == '0) begin
                st_frame = '0;
                st_dir   = 1'b0;
            end else if (dec_e >= cm1_e) begin
                st_frame = cm1;
                st_dir   = 1'b1;
            end else if (dec_e == '0) begin
                st_frame = '0;
                st_dir   = 1'b0;
            end else begin
                st_frame = dec_e[FI_W-1:0];
            end
        end else if (inc_e >= cnt_e) begin
            if (mode_once) begin
                st_frame = cm1;
                st_run   = 1'b0;
                st_fin   = 1'b1;
            end else begin
                st_frame = '0;
            end
        end else begin
            st_frame = inc_e[FI_W-1:0];
        end
    end

    assign total     = TOT_W'(r_frac) + TOT_W'(i_step);
    assign whole_e   = CW'(total[TOT_W-1:FRAC_BITS]);
    assign whole_cap = (whole_e > CW'(sfs_pkg::MAX_CROSS)) ? LW'(sfs_pkg::MAX_CROSS)
                                                           : whole_e[LW-1:0];

    // New frame for the position tracker.
    always_comb begin
        nf = r_frame;
        if (r_state == S_STEP) begin
            nf = st_frame;
        end else begin
            case (i_op)
                sfs_pkg::OP_RESTART, sfs_pkg::OP_REWIND: nf = '0;
                sfs_pkg::OP_SEEK: nf = i_seek;
                default: nf = r_frame;
            endcase
        end
    end

    // Column and row follow single steps and a jump to frame 0; any other jump needs a divide.
    assign nf_e    = {1'b0, nf};
    assign col_inc = {1'b0, r_col} + (COL_W + 1)'(1);

    always_comb begin
        pos_col = r_col;
        pos_row = r_row;
        pos_ok  = r_ok;
        if (nf == '0) begin
            pos_col = '0;
            pos_row = '0;
            pos_ok  = 1'b1;
        end else if (nf == r_frame) begin
            pos_ok = r_ok;
        end else if (nf_e == {1'b0, r_frame} + (FI_W + 1)'(1)) begin
            if (col_inc == {1'b0, i_cfg.sheet_columns}) begin
                pos_col = '0;
                pos_row = r_row + FI_W'(1);
            end else begin
                pos_col = col_inc[COL_W-1:0];
            end
        end else if (nf_e == {1'b0, r_frame} - (FI_W + 1)'(1)) begin
            if (r_col == '0) begin
                pos_col = i_cfg.sheet_columns - COL_W'(1);
                pos_row = r_row - FI_W'(1);
            end else begin
                pos_col = r_col - COL_W'(1);
            end
        end else begin
            pos_ok = 1'b0;
        end
    end

    assign div_start = (r_state == S_FIX) && !r_ok && (i_cfg.sheet_columns != '0);

    sfs_div #(
        .N_W (FI_W),
        .D_W (COL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_frame),
        .i_den   (i_cfg.sheet_columns),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign sum_x = SX_W'(r_px) + SX_W'(i_cfg.pad_x);
    assign sum_y = SY_W'(r_py) + SY_W'(i_cfg.pad_y);
    assign x_out = !coords_ok ? '0 :
                   (sum_x > SX_W'(16'hFFFF)) ? 16'hFFFF : sum_x[sfs_pkg::COORD_W-1:0];
    assign y_out = !coords_ok ? '0 :
                   (sum_y > SY_W'(16'hFFFF)) ? 16'hFFFF : sum_y[sfs_pkg::COORD_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_frame   = r_frame;
        n_dir     = r_dir;
        n_frac    = r_frac;
        n_run     = r_run;
        n_col     = r_col;
        n_row     = r_row;
        n_ok      = r_ok;
        n_left    = r_left;
        n_ev      = r_ev;
        n_fin     = r_fin;
        n_last    = r_last;
        n_px      = r_px;
        n_py      = r_py;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;
        o_pop     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    o_pop  = 1'b1;
                    n_ev   = 1'b0;
                    n_fin  = 1'b0;
                    n_last = 1'b1;
                    n_frame = nf;
                    n_col   = pos_col;
                    n_row   = pos_row;
                    n_ok    = pos_ok;
                    n_state = S_FIX;
                    case (i_op)
                        sfs_pkg::OP_TICK: begin
                            n_state = S_IDLE;
                            if (r_run && cnt_nz) begin
                                n_frac = total[FRAC_BITS-1:0];
                                if (whole_cap != '0 && !(mode_pp && cnt_e <= FE_W'(1))) begin
                                    n_left  = whole_cap;
                                    n_state = S_STEP;
                                end
                            end
                        end
                        sfs_pkg::OP_RESTART: begin
                            n_dir  = 1'b0;
                            n_frac = '0;
                            n_run  = cnt_nz;
                        end
                        sfs_pkg::OP_RESUME: n_run = cnt_nz;
                        sfs_pkg::OP_STOP:   n_run = 1'b0;
                        sfs_pkg::OP_REWIND: begin
                            n_dir  = 1'b0;
                            n_frac = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP: begin
                n_frame = st_frame;
                n_dir   = st_dir;
                n_run   = st_run;
                n_col   = pos_col;
                n_row   = pos_row;
                n_ok    = pos_ok;
                n_ev    = !st_fin;
                n_fin   = st_fin;
                n_last  = (r_left == LW'(1)) || st_fin;
                n_left  = r_left - LW'(1);
                n_state = S_FIX;
            end
            S_FIX: begin
                n_state = div_start ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_col   = div_rem;
                    n_row   = div_quot;
                    n_ok    = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_px    = RX_W'(r_col) * RX_W'(i_cfg.stride_x);
                n_py    = RY_W'(r_row) * RY_W'(i_cfg.stride_y);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{sfs_pkg::OUT_PAD_W{1'b0}}, r_dir, r_run, coords_ok,
                                 y_out, x_out, sfs_pkg::FRAME_OUT_W'(r_frame)};
                    n_m_user  = {r_fin, r_ev};
                    n_m_last  = r_last;
                    n_state   = r_last ? S_IDLE : S_STEP;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cols_wr) begin
            n_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_frame   <= '0;
            r_dir     <= 1'b0;
            r_frac    <= '0;
            r_run     <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_ok      <= 1'b1;
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_frame   <= n_frame;
            r_dir     <= n_dir;
            r_frac    <= n_frac;
            r_run     <= n_run;
            r_col     <= n_col;
            r_row     <= n_row;
            r_ok      <= n_ok;
            r_left    <= n_left;
            r_m_valid <= n_m_valid;
        end
        r_ev     <= n_ev;
        r_fin    <= n_fin;
        r_last   <= n_last;
        r_px     <= n_px;
        r_py     <= n_py;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

endmodule

`default_nettype wire

// ===== design/sprite_frame_sequencer.sv =====
// Sprite frame sequencer top level: configuration registers, front, queue and back.
//
//  channel   dir  handshake              payload
//  s (cmd)   in   i_s_tvalid/o_s_tready  tdata: phase_step, target_frame; tuser: func
//  m (res)   out  o_m_tvalid/i_m_tready  tdata: frame, x, y, flags; tuser: event, finish
//  cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
//  A command beat passes the front register and the queue before the back pops it. Each
//  result of a tick then passes the step, fix, multiply and output register states, the
//  last waiting on i_m_tready, up to 64 results; after a seek, a clamp or a column write,
//  the first result also waits on the bit-serial divider. Synchronous active-low reset, no
//  clearing pass. The queue lets the front take beats while the back waits on i_m_tready.
`default_nettype none

module sprite_frame_sequencer #(
    parameter int FRAME_MAX = sfs_pkg::FRAME_MAX_DEF,
    parameter int FRAC_BITS = sfs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // phase_step[21:0], target_frame[37:22], zero fill
    input  wire logic [sfs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // func[2:0]
    input  wire logic [sfs_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // cur_frame[7:0], src_x[23:8], src_y[39:24], coords_valid[40],
    // is_playing[41], going_back[42], zero fill
    output logic [sfs_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // frame_event[0], clip_finished[1]
    output logic [sfs_pkg::OUT_TUSER_W-1:0]        o_m_tuser,
    output logic                                   o_m_tlast,
    input  wire logic                              i_cfg_we,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int FI_W  = $clog2(FRAME_MAX);
    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam int EW    = (CNT_W > sfs_pkg::COUNT_W) ? CNT_W : sfs_pkg::COUNT_W;
    localparam int Q_W   = sfs_pkg::FUNC_W + sfs_pkg::PSTEP_W + FI_W;
    localparam logic [EW-1:0] FM_E = EW'(FRAME_MAX);

    sfs_pkg::t_cfg r_cfg, n_cfg;

    logic [EW-1:0]    fc_e;
    logic [CNT_W-1:0] cnt;
    logic             cols_wr;

    logic                        f_push, q_push_ready, q_pop_valid, q_pop;
    sfs_pkg::t_op                f_op, q_op;
    logic [sfs_pkg::PSTEP_W-1:0] f_step, q_step;
    logic [FI_W-1:0]             f_seek, q_seek;
    logic [Q_W-1:0]              q_din, q_dout;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfs_pkg::CFG_FRAME_COUNT:
                    n_cfg.frame_count = i_cfg_data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::CFG_PLAY_MODE:
                    n_cfg.play_mode = i_cfg_data[sfs_pkg::MODE_W-1:0];
                sfs_pkg::CFG_SHEET_COLUMNS:
                    n_cfg.sheet_columns = i_cfg_data[sfs_pkg::COLS_W-1:0];
                sfs_pkg::CFG_STRIDE_X:
                    n_cfg.stride_x = i_cfg_data[sfs_pkg::STRIDE_W-1:0];
                sfs_pkg::CFG_STRIDE_Y:
                    n_cfg.stride_y = i_cfg_data[sfs_pkg::STRIDE_W-1:0];
                sfs_pkg::CFG_PAD_X:
                    n_cfg.pad_x = i_cfg_data[sfs_pkg::PAD_W-1:0];
                sfs_pkg::CFG_PAD_Y:
                    n_cfg.pad_y = i_cfg_data[sfs_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign cols_wr = i_cfg_we && (i_cfg_idx == sfs_pkg::CFG_SHEET_COLUMNS);
    assign fc_e    = EW'(r_cfg.frame_count);
    assign cnt     = (fc_e < FM_E) ? fc_e[CNT_W-1:0] : FM_E[CNT_W-1:0];

    sfs_front #(
        .FI_W  (FI_W),
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_cnt        (cnt),
        .i_push_ready (q_push_ready),
        .o_push       (f_push),
        .o_op         (f_op),
        .o_step       (f_step),
        .o_seek       (f_seek)
    );

    assign q_din = {f_op, f_step, f_seek};

    sfs_queue #(
        .WIDTH (Q_W),
        .DEPTH (sfs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .i_data       (q_din),
        .o_push_ready (q_push_ready),
        .i_pop        (q_pop),
        .o_pop_valid  (q_pop_valid),
        .o_data       (q_dout)
    );

    assign q_op   = sfs_pkg::t_op'(q_dout[Q_W-1 -: sfs_pkg::FUNC_W]);
    assign q_step = q_dout[FI_W +: sfs_pkg::PSTEP_W];
    assign q_seek = q_dout[FI_W-1:0];

    sfs_back #(
        .FI_W      (FI_W),
        .CNT_W     (CNT_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .o_pop       (q_pop),
        .i_op        (q_op),
        .i_step      (q_step),
        .i_seek      (q_seek),
        .i_cnt       (cnt),
        .i_cfg       (r_cfg),
        .i_cols_wr   (cols_wr),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/sfs_checker.sv =====
// Port-level checks of the sprite frame sequencer, bound to the top level.
`default_nettype none

module sfs_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [sfs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input wire logic [sfs_pkg::OUT_TUSER_W-1:0]   o_m_tuser,
    input wire logic                              o_m_tlast
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result payload changed while stalled");

    a_event_xor_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("frame event and clip finish in one beat");

    a_finish_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast && !o_m_tdata[41])
        else $error("finish beat not last or still playing");

    a_no_coords_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[40] |-> o_m_tdata[39:8] == '0)
        else $error("coordinates nonzero while not valid");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

`default_nettype wire
